FILE: rtl/perspective_ray_direction_assert.svh
// assertion macros for the perspective ray direction block
// used by rtl/perspective_ray_direction.sv, needs clk_i and rst_ni in scope
`ifndef PERSPECTIVE_RAY_DIRECTION_ASSERT_SVH
`define PERSPECTIVE_RAY_DIRECTION_ASSERT_SVH
`ifndef SYNTHESIS
`define PRD_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("assertion failed");
`define PRD_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("assertion failed");
`else
`define PRD_ASSERT(lbl, expr)
`define PRD_ASSERT_IMPL(lbl, pre, post)
`endif
`endif

FILE: rtl/prd_pkg.sv
// shared types and widths for the perspective ray direction block
// no dependencies
package prd_pkg;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_X_HALF_EXTENT = 3'd2,
    REG_Y_HALF_EXTENT = 3'd3,
    REG_X_PIXEL_STEP  = 3'd4,
    REG_Y_PIXEL_STEP  = 3'd5
  } prd_reg_e;

  localparam int MagW  = 45;  // unnormalized component magnitude, q.25
  localparam int NormW = 30;  // magnitude after normalizing shift
  localparam int SqW   = 62;  // sum of squares
  localparam int RootW = 31;  // vector length
  localparam int NumW  = 53;  // dividend for the output scaling
  localparam int QW    = 23;  // quotient magnitude, up to 2^22
  localparam int DirW  = 24;  // q1.22 output

  typedef struct packed {
    logic oor;
    logic nx;
    logic ny;
  } prd_flags_t;

  typedef struct packed {
    logic [NormW-1:0] a;
    logic [NormW-1:0] b;
    logic [NormW-1:0] c;
  } prd_vec_t;

endpackage

FILE: rtl/perspective_ray_direction.sv
// top level of the pinhole camera primary ray direction block
// depends on prd_pkg, prd_isqrt, prd_div and perspective_ray_direction_assert.svh
//
// usage
// - slave stream: one beat per pixel, tdata = {pixel_row, pixel_column}
// - master stream: one beat per pixel, tdata = {dir_z, dir_y, dir_x} in
//   signed q1.22, tuser = out_of_range (directions zero when set)
// - config channel: cfg_index_i picks the register, cfg_data_i holds the
//   value, always ready; write only while no pixel is in flight
// - throughput: one pixel per cycle unless the output stalls; most depth is in
//   the 31-stage square root and the 23-stage divider, one result bit per stage
// - reset: all pipeline valids clear, registers return to a 640x480
//   view with unit half extents
// - backpressure: while the output beat waits, the whole pipeline holds
//   and s_axis_tready drops; nothing is lost or repeated
`include "perspective_ray_direction_assert.svh"
module perspective_ray_direction import prd_pkg::*; #(
  parameter int MAX_DIMENSION = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // pixel input
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [11:0] pixel_column, [23:12] pixel_row
  // ray direction output
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [23:0] dir_x, [47:24] dir_y, [71:48] dir_z
  output logic        m_axis_tuser    // [0] out_of_range
);

  localparam int DimW    = $clog2(MAX_DIMENSION + 1);
  localparam int CmpW    = (DimW > 13) ? DimW : 13;
  localparam int SqTermW = 2 * NormW;

  // config registers
  logic [12:0] width_q, height_q;
  logic [31:0] x_ext_q, y_ext_q, x_step_q, y_step_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
      x_ext_q  <= 32'd16777216;
      y_ext_q  <= 32'd16777216;
      x_step_q <= 32'd52429;
      y_step_q <= 32'd69905;
    end else if (cfg_valid_i) begin
      unique case (prd_reg_e'(cfg_index_i))
        REG_IMAGE_WIDTH:   width_q  <= cfg_data_i[12:0];
        REG_IMAGE_HEIGHT:  height_q <= cfg_data_i[12:0];
        REG_X_HALF_EXTENT: x_ext_q  <= cfg_data_i;
        REG_Y_HALF_EXTENT: y_ext_q  <= cfg_data_i;
        REG_X_PIXEL_STEP:  x_step_q <= cfg_data_i;
        REG_Y_PIXEL_STEP:  y_step_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // global advance: everything moves unless the output beat is stuck
  logic en;
  logic out_valid_q;
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  // stage 1: range check and step products
  logic [11:0]     col, row;
  logic [CmpW-1:0] w_eff, h_eff;
  logic            oor;
  assign col = s_axis_tdata[11:0];
  assign row = s_axis_tdata[23:12];

  always_comb begin
    w_eff = CmpW'(width_q);
    h_eff = CmpW'(height_q);
    if (w_eff > CmpW'(MAX_DIMENSION)) w_eff = CmpW'(MAX_DIMENSION);
    if (h_eff > CmpW'(MAX_DIMENSION)) h_eff = CmpW'(MAX_DIMENSION);
    oor = (CmpW'(col) >= w_eff) || (CmpW'(row) >= h_eff);
  end

  logic            v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;
  logic            oor1_q;
  logic [MagW-1:0] px1_q, py1_q;
  logic [32:0]     ex1_q, ey1_q;

  // stage 2: signed difference as sign and magnitude
  prd_flags_t      f2_q, f3_q, f4_q, f5_q, f6_q;
  logic [MagW-1:0] a2_q, b2_q;
  logic [MagW-1:0] ex_w, ey_w;
  assign ex_w = MagW'(ex1_q);
  assign ey_w = MagW'(ey1_q);

  // stage 3: normalizing shift count
  logic [MagW-1:0] a3_q, b3_q;
  logic [3:0]      s3_q;
  logic [MagW-1:0] m3;
  logic [3:0]      s_d;
  always_comb begin
    m3  = (a2_q > b2_q) ? a2_q : b2_q;
    s_d = '0;
    // smallest shift that leaves the largest magnitude below 2^30
    for (int i = NormW; i < MagW; i++) begin
      if (m3[i]) s_d = 4'(i - NormW + 1);
    end
  end

  // stage 4: shifted magnitudes
  prd_vec_t        vec4_q, vec5_q, vec6_q;
  logic [MagW-1:0] a_sh, b_sh;
  logic [NormW-1:0] c_sh;
  assign a_sh = a3_q >> s3_q;
  assign b_sh = b3_q >> s3_q;
  assign c_sh = (NormW'(1) << 25) >> s3_q;

  // stage 5: squares, stage 6: sum
  logic [2*NormW-1:0] sqa5_q, sqb5_q, sqc5_q;
  logic [SqW-1:0]     sum6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else if (en) begin
      v1_q <= s_axis_tvalid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oor1_q <= oor;
      px1_q  <= MagW'(x_step_q) * MagW'({col, 1'b1});
      py1_q  <= MagW'(y_step_q) * MagW'({row, 1'b1});
      ex1_q  <= {x_ext_q, 1'b0};
      ey1_q  <= {y_ext_q, 1'b0};

      f2_q.oor <= oor1_q;
      f2_q.nx  <= px1_q < ex_w;
      f2_q.ny  <= py1_q < ey_w;
      a2_q     <= (px1_q >= ex_w) ? px1_q - ex_w : ex_w - px1_q;
      b2_q     <= (py1_q >= ey_w) ? py1_q - ey_w : ey_w - py1_q;

      f3_q <= f2_q;
      a3_q <= a2_q;
      b3_q <= b2_q;
      s3_q <= s_d;

      f4_q     <= f3_q;
      vec4_q.a <= a_sh[NormW-1:0];
      vec4_q.b <= b_sh[NormW-1:0];
      vec4_q.c <= c_sh;

      f5_q   <= f4_q;
      vec5_q <= vec4_q;
      sqa5_q <= SqTermW'(vec4_q.a) * SqTermW'(vec4_q.a);
      sqb5_q <= SqTermW'(vec4_q.b) * SqTermW'(vec4_q.b);
      sqc5_q <= SqTermW'(vec4_q.c) * SqTermW'(vec4_q.c);

      f6_q   <= f5_q;
      vec6_q <= vec5_q;
      sum6_q <= SqW'(sqa5_q) + SqW'(sqb5_q) + SqW'(sqc5_q);
    end
  end

  // vector length
  logic             sq_valid;
  logic [RootW-1:0] len;
  prd_vec_t         sq_vec;
  prd_flags_t       sq_flags;

  prd_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v6_q),
    .sq_i    (sum6_q),
    .vec_i   (vec6_q),
    .flags_i (f6_q),
    .valid_o (sq_valid),
    .root_o  (len),
    .vec_o   (sq_vec),
    .flags_o (sq_flags)
  );

  // stage 7: dividends with half the divisor added for rounding
  logic [2:0][NumW-1:0] num7_q;
  logic [RootW-1:0]     len7_q;
  prd_flags_t           f7_q;
  logic [NumW-1:0]      half_len;
  assign half_len = NumW'(len >> 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (en) begin
      v7_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num7_q[0] <= {1'b0, sq_vec.a, 22'b0} + half_len;
      num7_q[1] <= {1'b0, sq_vec.b, 22'b0} + half_len;
      num7_q[2] <= {1'b0, sq_vec.c, 22'b0} + half_len;
      len7_q    <= len;
      f7_q      <= sq_flags;
    end
  end

  logic               dv_valid;
  logic [2:0][QW-1:0] quot;
  prd_flags_t         dv_flags;

  prd_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (v7_q),
    .num_i   (num7_q),
    .den_i   (len7_q),
    .flags_i (f7_q),
    .valid_o (dv_valid),
    .quot_o  (quot),
    .flags_o (dv_flags)
  );

  // output register: apply signs, zero out-of-range pixels
  logic [DirW-1:0] dx_q, dy_q, dz_q;
  logic            oor_q;
  logic [DirW-1:0] qx, qy, qz;
  assign qx = DirW'(quot[0]);
  assign qy = DirW'(quot[1]);
  assign qz = DirW'(quot[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      oor_q <= dv_flags.oor;
      if (dv_flags.oor) begin
        dx_q <= '0;
        dy_q <= '0;
        dz_q <= '0;
      end else begin
        dx_q <= dv_flags.nx ? -qx : qx;
        dy_q <= dv_flags.ny ? -qy : qy;
        dz_q <= -qz;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {dz_q, dy_q, dx_q};
  assign m_axis_tuser  = oor_q;

  `PRD_ASSERT(a_ready_follows_output, s_axis_tready == (!m_axis_tvalid || m_axis_tready))
  `PRD_ASSERT_IMPL(a_oor_zero, m_axis_tvalid && oor_q, dx_q == '0 && dy_q == '0 && dz_q == '0)
  `PRD_ASSERT_IMPL(a_z_negative, m_axis_tvalid && !oor_q, dz_q[DirW-1] == 1'b1)
  `PRD_ASSERT_IMPL(a_stall_holds_pipe, $past(m_axis_tvalid && !m_axis_tready) && $past(rst_ni),
                   $stable(m_axis_tdata) && m_axis_tvalid)

endmodule

FILE: rtl/prd_isqrt.sv
// pipelined integer square root, one root bit per stage
// depends on prd_pkg
module prd_isqrt import prd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [SqW-1:0]   sq_i,
  input  prd_vec_t         vec_i,
  input  prd_flags_t       flags_i,
  output logic             valid_o,
  output logic [RootW-1:0] root_o,
  output prd_vec_t         vec_o,
  output prd_flags_t       flags_o
);

  logic             v_q     [RootW];
  logic [SqW-1:0]   rem_q   [RootW];
  logic [RootW-1:0] root_q  [RootW];
  prd_vec_t         vec_q   [RootW];
  prd_flags_t       flags_q [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    localparam int Bit = RootW - 1 - k;
    logic             v_in;
    logic [SqW-1:0]   rem_in;
    logic [RootW-1:0] root_in;
    prd_vec_t         vec_in;
    prd_flags_t       flags_in;
    logic [SqW-1:0]   trial;
    logic [SqW-1:0]   rem_d;
    logic [RootW-1:0] root_d;

    if (k == 0) begin : g_first
      assign v_in     = valid_i;
      assign rem_in   = sq_i;
      assign root_in  = '0;
      assign vec_in   = vec_i;
      assign flags_in = flags_i;
    end else begin : g_next
      assign v_in     = v_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign vec_in   = vec_q[k-1];
      assign flags_in = flags_q[k-1];
    end

    // trial = (2*root + 2^bit) * 2^bit
    assign trial = ({{(SqW-RootW){1'b0}}, root_in} << (Bit + 1))
                 + ({{(SqW-1){1'b0}}, 1'b1} << (2 * Bit));

    always_comb begin
      rem_d  = rem_in;
      root_d = root_in;
      if (rem_in >= trial) begin
        rem_d       = rem_in - trial;
        root_d[Bit] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]   <= rem_d;
        root_q[k]  <= root_d;
        vec_q[k]   <= vec_in;
        flags_q[k] <= flags_in;
      end
    end
  end

  assign valid_o = v_q[RootW-1];
  assign root_o  = root_q[RootW-1];
  assign vec_o   = vec_q[RootW-1];
  assign flags_o = flags_q[RootW-1];

endmodule

FILE: rtl/prd_div.sv
// pipelined restoring divider, three lanes sharing one divisor
// depends on prd_pkg
module prd_div import prd_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [2:0][NumW-1:0] num_i,
  input  logic [RootW-1:0]     den_i,
  input  prd_flags_t           flags_i,
  output logic                 valid_o,
  output logic [2:0][QW-1:0]   quot_o,
  output prd_flags_t           flags_o
);

  logic                 v_q     [QW];
  logic [2:0][NumW-1:0] rem_q   [QW];
  logic [2:0][QW-1:0]   quot_q  [QW];
  logic [RootW-1:0]     den_q   [QW];
  prd_flags_t           flags_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int Bit = QW - 1 - k;
    logic                 v_in;
    logic [2:0][NumW-1:0] rem_in;
    logic [2:0][QW-1:0]   quot_in;
    logic [RootW-1:0]     den_in;
    prd_flags_t           flags_in;
    logic [NumW-1:0]      den_sh;
    logic [2:0][NumW-1:0] rem_d;
    logic [2:0][QW-1:0]   quot_d;

    if (k == 0) begin : g_first
      assign v_in     = valid_i;
      assign rem_in   = num_i;
      assign quot_in  = '0;
      assign den_in   = den_i;
      assign flags_in = flags_i;
    end else begin : g_next
      assign v_in     = v_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign quot_in  = quot_q[k-1];
      assign den_in   = den_q[k-1];
      assign flags_in = flags_q[k-1];
    end

    assign den_sh = {{(NumW-RootW){1'b0}}, den_in} << Bit;

    always_comb begin
      rem_d  = rem_in;
      quot_d = quot_in;
      for (int l = 0; l < 3; l++) begin
        if (rem_in[l] >= den_sh) begin
          rem_d[l]       = rem_in[l] - den_sh;
          quot_d[l][Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]   <= rem_d;
        quot_q[k]  <= quot_d;
        den_q[k]   <= den_in;
        flags_q[k] <= flags_in;
      end
    end
  end

  assign valid_o = v_q[QW-1];
  assign quot_o  = quot_q[QW-1];
  assign flags_o = flags_q[QW-1];

endmodule
